/* rtl/lhsd_pkg.sv */
// ----------------------------------------------------------------------------
// lhsd_pkg
// Shared constants and types of the level Huffman stream decoder.
// ----------------------------------------------------------------------------
package lhsd_pkg;

  localparam int MAX_LEVELS_DEF   = 24;
  localparam int SYMBOL_SLOTS_DEF = 256;

  localparam logic [7:0] MAGIC_FIRST  = 8'o037;
  localparam logic [7:0] MAGIC_SECOND = 8'o036;

  localparam logic [2:0] KIND_SYMBOL      = 3'd0;
  localparam logic [2:0] KIND_OK          = 3'd1;
  localparam logic [2:0] KIND_BAD_MAGIC   = 3'd2;
  localparam logic [2:0] KIND_OLD_FORMAT  = 3'd3;
  localparam logic [2:0] KIND_BAD_LEVELS  = 3'd4;
  localparam logic [2:0] KIND_MANY_LEAVES = 3'd5;
  localparam logic [2:0] KIND_BAD_CODE    = 3'd6;
  localparam logic [2:0] KIND_MISMATCH    = 3'd7;

  typedef enum logic [3:0] {
    PH_MAGIC0,
    PH_MAGIC1,
    PH_SIZE,
    PH_LEVELS,
    PH_COUNTS,
    PH_LEAVES,
    PH_ENDLEAF,
    PH_DATA,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADV,
    S_BUILD,
    S_BIT,
    S_SYM,
    S_END,
    S_FLUSH
  } state_t;

endpackage

/* rtl/lhsd_ram.sv */
// ----------------------------------------------------------------------------
// lhsd_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module lhsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/level_huffman_stream_decoder_unit.sv */
// ----------------------------------------------------------------------------
// level_huffman_stream_decoder_unit
// Parses a packed Huffman header and decodes the code bits into bytes.
// ----------------------------------------------------------------------------
// header word: accept, end-of-input check and flush of the last result
// leaf count and leaf words: plus the level check state, which steps past each level completed
// last leaf word: plus the internal count pass over every level, from the deepest up
// data word: up to 8 tree steps, plus one symbol store read per symbol
// one word at a time; a full output register stalls the walk
// reset returns to the first magic byte; the symbol store is not cleared
module level_huffman_stream_decoder_unit #(
  parameter int MAX_LEVELS   = lhsd_pkg::MAX_LEVELS_DEF,
  parameter int SYMBOL_SLOTS = lhsd_pkg::SYMBOL_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] kind,
  output logic [7:0] symbol,
  output logic       last
);

  localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int AW = (SYMBOL_SLOTS > 1) ? $clog2(SYMBOL_SLOTS) : 1;

  lhsd_pkg::state_t state, state_next;
  lhsd_pkg::phase_t phase, phase_next;

  logic [4:0]  hdr_idx, hdr_idx_next;
  logic [31:0] original_size, original_size_next;
  logic [4:0]  level_total, level_total_next;
  logic [8:0]  end_position, end_position_next;
  logic [4:0]  decode_level, decode_level_next;
  logic [9:0]  partial_code, partial_code_next;
  logic [31:0] emitted_count, emitted_count_next;
  logic [2:0]  bit_cnt, bit_cnt_next;
  logic [4:0]  bld, bld_next;
  logic [9:0]  nchild, nchild_next;
  logic [7:0]  data_r;
  logic        eoi_r;

  logic        pend_valid, pend_valid_next;
  logic [2:0]  pend_kind, pend_kind_next;
  logic [7:0]  pend_sym, pend_sym_next;

  logic [8:0] leaf_counts [MAX_LEVELS];
  logic [8:0] internal_counts [MAX_LEVELS];
  logic [7:0] level_start [MAX_LEVELS];

  logic          lc_we, ic_we, ls_we;
  logic [LW-1:0] lc_wa, ic_wa, ls_wa;
  logic [8:0]    lc_wd, ic_wd;
  logic [7:0]    ls_wd;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic       gen;
  logic [2:0] gen_kind;
  logic [7:0] gen_sym;
  logic       push, push_last;
  logic [2:0] push_kind;
  logic [7:0] push_sym;
  logic       out_free, slot_ok, accept;

  logic [4:0]  lvm1, hdr_inc;
  logic [9:0]  code, diff, half;
  logic [10:0] pos;
  logic [8:0]  ic_v, adv_span, bld_c;
  logic [7:0]  ls_v;
  logic        adv_go;

  assign out_free = !out_valid || out_ready;
  assign slot_ok  = !pend_valid || out_free;
  assign in_ready = (state == lhsd_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;

  assign lvm1    = decode_level - 5'd1;
  assign hdr_inc = hdr_idx + 5'd1;
  assign code    = {partial_code[8:0], data_r[bit_cnt]};
  assign ic_v    = internal_counts[lvm1[LW-1:0]];
  assign ls_v    = level_start[lvm1[LW-1:0]];
  assign diff    = code - {1'b0, ic_v};
  assign pos     = {3'b000, ls_v} + {1'b0, diff};
  assign adv_span = end_position - {1'b0, level_start[hdr_idx[LW-1:0]]};
  assign adv_go  = (hdr_idx < level_total) && (adv_span >= leaf_counts[hdr_idx[LW-1:0]]);
  assign half    = nchild >> 1;
  assign bld_c   = leaf_counts[bld[LW-1:0]] + ((bld == level_total - 5'd1) ? 9'd2 : 9'd0);

  lhsd_ram #(
    .WIDTH (8),
    .DEPTH (SYMBOL_SLOTS)
  ) u_symbol_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next         = state;
    phase_next         = phase;
    hdr_idx_next       = hdr_idx;
    original_size_next = original_size;
    level_total_next   = level_total;
    end_position_next  = end_position;
    decode_level_next  = decode_level;
    partial_code_next  = partial_code;
    emitted_count_next = emitted_count;
    bit_cnt_next       = bit_cnt;
    bld_next           = bld;
    nchild_next        = nchild;
    lc_we = 1'b0; lc_wa = hdr_idx[LW-1:0]; lc_wd = {1'b0, data_byte};
    ic_we = 1'b0; ic_wa = bld[LW-1:0];     ic_wd = half[8:0];
    ls_we = 1'b0; ls_wa = '0;              ls_wd = '0;
    ram_we = 1'b0; ram_waddr = end_position[AW-1:0]; ram_wdata = data_byte;
    ram_re = 1'b0; ram_raddr = pos[AW-1:0];
    gen = 1'b0; gen_kind = lhsd_pkg::KIND_SYMBOL; gen_sym = 8'd0;
    push = 1'b0; push_last = 1'b0; push_kind = pend_kind; push_sym = pend_sym;
    pend_valid_next = pend_valid;
    pend_kind_next  = pend_kind;
    pend_sym_next   = pend_sym;

    unique case (state)
      lhsd_pkg::S_IDLE: begin
        if (accept) begin
          state_next = lhsd_pkg::S_END;
          unique case (phase)
            lhsd_pkg::PH_MAGIC0: begin
              if (data_byte != lhsd_pkg::MAGIC_FIRST) begin
                gen = 1'b1; gen_kind = lhsd_pkg::KIND_BAD_MAGIC;
                phase_next = lhsd_pkg::PH_DONE;
              end else begin
                phase_next = lhsd_pkg::PH_MAGIC1;
              end
            end
            lhsd_pkg::PH_MAGIC1: begin
              if (data_byte == lhsd_pkg::MAGIC_FIRST) begin
                gen = 1'b1; gen_kind = lhsd_pkg::KIND_OLD_FORMAT;
                phase_next = lhsd_pkg::PH_DONE;
              end else if (data_byte != lhsd_pkg::MAGIC_SECOND) begin
                gen = 1'b1; gen_kind = lhsd_pkg::KIND_BAD_MAGIC;
                phase_next = lhsd_pkg::PH_DONE;
              end else begin
                phase_next = lhsd_pkg::PH_SIZE;
                hdr_idx_next = 5'd0;
                original_size_next = 32'd0;
              end
            end
            lhsd_pkg::PH_SIZE: begin
              original_size_next = {original_size[23:0], data_byte};
              hdr_idx_next = hdr_inc;
              if (hdr_idx == 5'd3) begin
                phase_next = lhsd_pkg::PH_LEVELS;
              end
            end
            lhsd_pkg::PH_LEVELS: begin
              if (data_byte == 8'd0 || data_byte > 8'(MAX_LEVELS)) begin
                gen = 1'b1; gen_kind = lhsd_pkg::KIND_BAD_LEVELS;
                phase_next = lhsd_pkg::PH_DONE;
              end else begin
                level_total_next = data_byte[4:0];
                hdr_idx_next = 5'd0;
                phase_next = lhsd_pkg::PH_COUNTS;
              end
            end
            lhsd_pkg::PH_COUNTS: begin
              lc_we = 1'b1;
              hdr_idx_next = hdr_inc;
              if (hdr_inc >= level_total) begin
                hdr_idx_next = 5'd0;
                end_position_next = 9'd0;
                ls_we = 1'b1; ls_wa = '0; ls_wd = 8'd0;
                phase_next = lhsd_pkg::PH_LEAVES;
                state_next = lhsd_pkg::S_ADV;
              end
            end
            lhsd_pkg::PH_LEAVES: begin
              if (end_position >= 9'(SYMBOL_SLOTS - 1)) begin
                gen = 1'b1; gen_kind = lhsd_pkg::KIND_MANY_LEAVES;
                phase_next = lhsd_pkg::PH_DONE;
              end else begin
                ram_we = 1'b1;
                end_position_next = end_position + 9'd1;
                state_next = lhsd_pkg::S_ADV;
              end
            end
            lhsd_pkg::PH_ENDLEAF: begin
              ram_we = 1'b1;
              end_position_next = end_position + 9'd1;
              decode_level_next = 5'd1;
              partial_code_next = 10'd0;
              emitted_count_next = 32'd0;
              phase_next = lhsd_pkg::PH_DATA;
              bld_next = level_total - 5'd1;
              nchild_next = 10'd0;
              state_next = lhsd_pkg::S_BUILD;
            end
            lhsd_pkg::PH_DATA: begin
              bit_cnt_next = 3'd7;
              state_next = lhsd_pkg::S_BIT;
            end
            default: begin
            end
          endcase
        end
      end
      lhsd_pkg::S_ADV: begin
        if (adv_go) begin
          hdr_idx_next = hdr_inc;
          if (hdr_inc < level_total) begin
            ls_we = 1'b1; ls_wa = hdr_inc[LW-1:0]; ls_wd = end_position[7:0];
          end
        end else begin
          if (hdr_idx >= level_total) begin
            phase_next = lhsd_pkg::PH_ENDLEAF;
          end
          state_next = lhsd_pkg::S_END;
        end
      end
      lhsd_pkg::S_BUILD: begin
        ic_we = 1'b1;
        nchild_next = half + {1'b0, bld_c};
        if (bld == 5'd0) begin
          state_next = lhsd_pkg::S_END;
        end else begin
          bld_next = bld - 5'd1;
        end
      end
      lhsd_pkg::S_BIT: begin
        if (slot_ok) begin
          if (decode_level == 5'd0 || decode_level > level_total) begin
            gen = 1'b1; gen_kind = lhsd_pkg::KIND_BAD_CODE;
            phase_next = lhsd_pkg::PH_DONE;
            state_next = lhsd_pkg::S_END;
          end else if (code >= {1'b0, ic_v}) begin
            if (pos == {2'b00, end_position}) begin
              gen = 1'b1;
              gen_kind = (emitted_count == original_size) ?
                         lhsd_pkg::KIND_OK : lhsd_pkg::KIND_MISMATCH;
              phase_next = lhsd_pkg::PH_DONE;
              state_next = lhsd_pkg::S_END;
            end else if (pos > {2'b00, end_position}) begin
              gen = 1'b1; gen_kind = lhsd_pkg::KIND_BAD_CODE;
              phase_next = lhsd_pkg::PH_DONE;
              state_next = lhsd_pkg::S_END;
            end else begin
              ram_re = 1'b1;
              emitted_count_next = emitted_count + 32'd1;
              decode_level_next = 5'd1;
              partial_code_next = 10'd0;
              state_next = lhsd_pkg::S_SYM;
            end
          end else begin
            partial_code_next = code;
            decode_level_next = decode_level + 5'd1;
            if (bit_cnt == 3'd0) begin
              state_next = lhsd_pkg::S_END;
            end else begin
              bit_cnt_next = bit_cnt - 3'd1;
            end
          end
        end
      end
      lhsd_pkg::S_SYM: begin
        if (slot_ok) begin
          gen = 1'b1; gen_kind = lhsd_pkg::KIND_SYMBOL; gen_sym = ram_rdata;
          if (bit_cnt == 3'd0) begin
            state_next = lhsd_pkg::S_END;
          end else begin
            bit_cnt_next = bit_cnt - 3'd1;
            state_next = lhsd_pkg::S_BIT;
          end
        end
      end
      lhsd_pkg::S_END: begin
        if (slot_ok) begin
          if (eoi_r && phase != lhsd_pkg::PH_DONE) begin
            gen = 1'b1;
            if (phase == lhsd_pkg::PH_DATA) begin
              gen_kind = (original_size == 32'd0 && emitted_count == 32'd0) ?
                         lhsd_pkg::KIND_OK : lhsd_pkg::KIND_MISMATCH;
            end else begin
              gen_kind = lhsd_pkg::KIND_BAD_MAGIC;
            end
            phase_next = lhsd_pkg::PH_DONE;
          end
          state_next = lhsd_pkg::S_FLUSH;
        end
      end
      lhsd_pkg::S_FLUSH: begin
        if (!pend_valid) begin
          state_next = lhsd_pkg::S_IDLE;
        end else if (out_free) begin
          push = 1'b1; push_last = 1'b1;
          pend_valid_next = 1'b0;
          state_next = lhsd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lhsd_pkg::S_IDLE;
      end
    endcase

    if (gen) begin
      if (pend_valid) begin
        push = 1'b1; push_last = 1'b0;
      end
      pend_valid_next = 1'b1;
      pend_kind_next  = gen_kind;
      pend_sym_next   = gen_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= lhsd_pkg::S_IDLE;
      phase         <= lhsd_pkg::PH_MAGIC0;
      hdr_idx       <= 5'd0;
      original_size <= 32'd0;
      level_total   <= 5'd0;
      end_position  <= 9'd0;
      decode_level  <= 5'd1;
      partial_code  <= 10'd0;
      emitted_count <= 32'd0;
      bit_cnt       <= 3'd0;
      bld           <= 5'd0;
      nchild        <= 10'd0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      phase         <= phase_next;
      hdr_idx       <= hdr_idx_next;
      original_size <= original_size_next;
      level_total   <= level_total_next;
      end_position  <= end_position_next;
      decode_level  <= decode_level_next;
      partial_code  <= partial_code_next;
      emitted_count <= emitted_count_next;
      bit_cnt       <= bit_cnt_next;
      bld           <= bld_next;
      nchild        <= nchild_next;
      pend_valid    <= pend_valid_next;
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= data_byte;
      eoi_r  <= end_of_input;
    end
    pend_kind <= pend_kind_next;
    pend_sym  <= pend_sym_next;
    if (push) begin
      kind   <= push_kind;
      symbol <= push_sym;
      last   <= push_last;
    end
    if (lc_we) begin
      leaf_counts[lc_wa] <= lc_wd;
    end
    if (ic_we) begin
      internal_counts[ic_wa] <= ic_wd;
    end
    if (ls_we) begin
      level_start[ls_wa] <= ls_wd;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    phase == lhsd_pkg::PH_DONE |=> phase == lhsd_pkg::PH_DONE)
    else $error("finished stream left the done phase");

  a_finish_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != lhsd_pkg::KIND_SYMBOL |-> last)
    else $error("status word not marked last");

  a_walk_in_data: assert property (@(posedge clk) disable iff (rst)
    state == lhsd_pkg::S_BIT || state == lhsd_pkg::S_SYM |->
      phase == lhsd_pkg::PH_DATA)
    else $error("tree walk outside data phase");

  a_no_push_blocked: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("result pushed into a full output register");
`endif

endmodule

/* sim/lhsd_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lhsd_checker
// Watches both channels of the decoder, predicts each result word from the
// accepted input words and compares kind, symbol and last in order.
// ----------------------------------------------------------------------------
module lhsd_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_input,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [2:0] kind,
  input  logic [7:0] symbol,
  input  logic       last,
  output int         pending,
  output int         errors,
  output int         results_seen
);

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] sym;
    logic       last;
  } result_t;

  result_t expected_q[$];

  lhsd_pkg::phase_t phase;
  int unsigned hdr_idx;
  int unsigned orig_size;
  int unsigned lvl_total;
  int unsigned leaf_cnt[lhsd_pkg::MAX_LEVELS_DEF];
  int unsigned node_cnt[lhsd_pkg::MAX_LEVELS_DEF];
  int unsigned lvl_start[lhsd_pkg::MAX_LEVELS_DEF];
  logic [7:0]  sym_store[lhsd_pkg::SYMBOL_SLOTS_DEF];
  int unsigned end_pos;
  int unsigned dec_lvl;
  int unsigned code_acc;
  int unsigned sym_count;
  int          byte_results;

  assign pending = expected_q.size();

  function automatic void push_result(input logic [2:0] k, input logic [7:0] s);
    result_t r;
    r.kind = k;
    r.sym  = s;
    r.last = 1'b0;
    expected_q.push_back(r);
    byte_results++;
  endfunction

  function automatic void stop_stream(input logic [2:0] k);
    push_result(k, 8'd0);
    phase = lhsd_pkg::PH_DONE;
  endfunction

  function automatic void next_level();
    while (hdr_idx < lvl_total && hdr_idx < lhsd_pkg::MAX_LEVELS_DEF &&
           end_pos - lvl_start[hdr_idx] >= leaf_cnt[hdr_idx]) begin
      hdr_idx++;
      if (hdr_idx < lvl_total && hdr_idx < lhsd_pkg::MAX_LEVELS_DEF)
        lvl_start[hdr_idx] = end_pos & 8'hff;
    end
    if (hdr_idx >= lvl_total) phase = lhsd_pkg::PH_ENDLEAF;
  endfunction

  function automatic void count_nodes();
    int unsigned nchild;
    int unsigned lv;
    nchild = 0;
    if (lvl_total < 1 || lvl_total > lhsd_pkg::MAX_LEVELS_DEF) return;
    leaf_cnt[lvl_total-1] = (leaf_cnt[lvl_total-1] + 2) & 9'h1ff;
    for (lv = lvl_total; lv >= 1; lv--) begin
      nchild = nchild / 2;
      node_cnt[lv-1] = nchild & 9'h1ff;
      nchild += leaf_cnt[lv-1];
    end
  endfunction

  function automatic void walk_bits(input logic [7:0] b);
    int unsigned code;
    int unsigned pos;
    int          i;
    for (i = 7; i >= 0 && phase == lhsd_pkg::PH_DATA; i--) begin
      code = (code_acc * 2 + b[i]) & 10'h3ff;
      if (dec_lvl < 1 || dec_lvl > lvl_total || dec_lvl > lhsd_pkg::MAX_LEVELS_DEF) begin
        stop_stream(lhsd_pkg::KIND_BAD_CODE);
        return;
      end
      if (code >= node_cnt[dec_lvl-1]) begin
        pos = lvl_start[dec_lvl-1] + (code - node_cnt[dec_lvl-1]);
        if (pos == end_pos) begin
          stop_stream(sym_count == orig_size ? lhsd_pkg::KIND_OK : lhsd_pkg::KIND_MISMATCH);
          return;
        end
        if (pos > end_pos || pos >= lhsd_pkg::SYMBOL_SLOTS_DEF) begin
          stop_stream(lhsd_pkg::KIND_BAD_CODE);
          return;
        end
        push_result(lhsd_pkg::KIND_SYMBOL, sym_store[pos]);
        sym_count++;
        dec_lvl  = 1;
        code_acc = 0;
      end else begin
        code_acc = code;
        dec_lvl  = (dec_lvl + 1) & 5'h1f;
      end
    end
  endfunction

  function automatic void predict_word(input logic [7:0] b, input logic eoi);
    result_t r;
    byte_results = 0;
    case (phase)
      lhsd_pkg::PH_MAGIC0: begin
        if (b != lhsd_pkg::MAGIC_FIRST) stop_stream(lhsd_pkg::KIND_BAD_MAGIC);
        else phase = lhsd_pkg::PH_MAGIC1;
      end
      lhsd_pkg::PH_MAGIC1: begin
        if (b == lhsd_pkg::MAGIC_FIRST) stop_stream(lhsd_pkg::KIND_OLD_FORMAT);
        else if (b != lhsd_pkg::MAGIC_SECOND) stop_stream(lhsd_pkg::KIND_BAD_MAGIC);
        else begin
          phase = lhsd_pkg::PH_SIZE;
          hdr_idx = 0;
          orig_size = 0;
        end
      end
      lhsd_pkg::PH_SIZE: begin
        orig_size = (orig_size << 8) | b;
        hdr_idx++;
        if (hdr_idx >= 4) phase = lhsd_pkg::PH_LEVELS;
      end
      lhsd_pkg::PH_LEVELS: begin
        if (b == 0 || b > lhsd_pkg::MAX_LEVELS_DEF) stop_stream(lhsd_pkg::KIND_BAD_LEVELS);
        else begin
          lvl_total = 32'(b);
          hdr_idx = 0;
          phase = lhsd_pkg::PH_COUNTS;
        end
      end
      lhsd_pkg::PH_COUNTS: begin
        if (hdr_idx < lhsd_pkg::MAX_LEVELS_DEF) leaf_cnt[hdr_idx] = 32'(b);
        hdr_idx++;
        if (hdr_idx >= lvl_total) begin
          hdr_idx = 0;
          end_pos = 0;
          lvl_start[0] = 0;
          phase = lhsd_pkg::PH_LEAVES;
          next_level();
        end
      end
      lhsd_pkg::PH_LEAVES: begin
        if (end_pos >= lhsd_pkg::SYMBOL_SLOTS_DEF - 1) stop_stream(lhsd_pkg::KIND_MANY_LEAVES);
        else begin
          sym_store[end_pos] = b;
          end_pos++;
          next_level();
        end
      end
      lhsd_pkg::PH_ENDLEAF: begin
        if (end_pos < lhsd_pkg::SYMBOL_SLOTS_DEF) sym_store[end_pos] = b;
        end_pos = (end_pos + 1) & 9'h1ff;
        count_nodes();
        dec_lvl = 1;
        code_acc = 0;
        sym_count = 0;
        phase = lhsd_pkg::PH_DATA;
      end
      lhsd_pkg::PH_DATA: walk_bits(b);
      default: return;
    endcase
    if (eoi && phase != lhsd_pkg::PH_DONE) begin
      if (phase == lhsd_pkg::PH_DATA)
        stop_stream((orig_size == 0 && sym_count == 0) ?
                    lhsd_pkg::KIND_OK : lhsd_pkg::KIND_MISMATCH);
      else
        stop_stream(lhsd_pkg::KIND_BAD_MAGIC);
    end
    if (byte_results > 0) begin
      r = expected_q[$];
      r.last = 1'b1;
      expected_q[$] = r;
    end
  endfunction

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      phase = lhsd_pkg::PH_MAGIC0;
      hdr_idx = 0;
      orig_size = 0;
      lvl_total = 0;
      end_pos = 0;
      dec_lvl = 1;
      code_acc = 0;
      sym_count = 0;
      foreach (sym_store[i]) sym_store[i] = 8'd0;
      foreach (leaf_cnt[i]) begin
        leaf_cnt[i] = 0;
        node_cnt[i] = 0;
        lvl_start[i] = 0;
      end
      expected_q.delete();
      errors <= 0;
      results_seen <= 0;
    end else begin
      if (in_valid && in_ready) predict_word(data_byte, end_of_input);
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected word kind=%0d symbol=%0d last=%0b",
                     $realtime, kind, symbol, last);
          errors <= errors + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.kind !== kind || exp_r.sym !== symbol || exp_r.last !== last) begin
            if (errors < 10)
              $display("%0t: mismatch expected kind=%0d symbol=%0d last=%0b, got %0d %0d %0b",
                       $realtime, exp_r.kind, exp_r.sym, exp_r.last, kind, symbol, last);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Builds a random canonical code tree, sends its packed header and a long
// coded stream ending in the end code, then noise; the checker does the rest.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LIMIT = 20000;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       end_of_input;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] kind;
  logic [7:0] symbol;
  logic       last;
  int         pending;
  int         errors;
  int         results_seen;

  logic [7:0]  stream_q[$];
  logic        eoi_q[$];
  int          word_idx;
  int          hold_at;
  int          idle_tx;
  int          idle_rx;
  int          quiet;
  int          n_levels;
  int          n_slots;
  int          n_syms;

  level_huffman_stream_decoder_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .end_of_input(end_of_input),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .symbol(symbol), .last(last)
  );

  lhsd_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .end_of_input(end_of_input),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .symbol(symbol), .last(last),
    .pending(pending), .errors(errors), .results_seen(results_seen)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // build the tree, the header and the coded stream
  task automatic build_stream();
    int unsigned avail;
    int unsigned leaves;
    int unsigned node_total;
    int unsigned total;
    int          lv;
    int          j;
    int          pos;
    int          hdr_len;
    int          stored[24];
    int          code_of[256];
    int          len_of[256];
    logic        bits_q[$];
    logic [7:0]  b;
    n_levels = ($urandom_range(0, 3) == 0) ? 24 : $urandom_range(1, 8);
    avail = 2;
    pos = 0;
    total = 0;
    for (lv = 1; lv <= n_levels; lv++) begin
      if (lv < n_levels) begin
        leaves = $urandom_range(0, avail - 1);
        if (avail > 32 && leaves < avail - 32) leaves = avail - 32;
        if (total > 100) leaves = avail - 1;
        node_total = avail - leaves;
        stored[lv-1] = leaves;
      end else begin
        leaves = avail;
        node_total = 0;
        stored[lv-1] = avail - 2;
      end
      for (j = 0; j < leaves; j++) begin
        code_of[pos] = node_total + j;
        len_of[pos] = lv;
        pos++;
      end
      total += leaves;
      avail = node_total * 2;
    end
    n_slots = pos - 1;
    n_syms = 0;
    hdr_len = 7 + n_levels + n_slots;
    while (bits_q.size() < 8 * (464 - hdr_len)) begin
      pos = $urandom_range(0, n_slots - 1);
      for (j = len_of[pos] - 1; j >= 0; j--) bits_q.push_back(1'(code_of[pos] >> j));
      n_syms++;
    end
    for (j = len_of[n_slots] - 1; j >= 0; j--) bits_q.push_back(1'(code_of[n_slots] >> j));
    while (bits_q.size() % 8 != 0) bits_q.push_back(1'($urandom_range(0, 1)));

    stream_q.push_back(lhsd_pkg::MAGIC_FIRST);
    stream_q.push_back(lhsd_pkg::MAGIC_SECOND);
    for (j = 3; j >= 0; j--) stream_q.push_back(8'(n_syms >> (8 * j)));
    stream_q.push_back(8'(n_levels));
    for (lv = 0; lv < n_levels; lv++) stream_q.push_back(8'(stored[lv]));
    for (j = 0; j < n_slots; j++) stream_q.push_back(8'($urandom_range(0, 255)));
    foreach (stream_q[i]) eoi_q.push_back(1'b0);
    hold_at = stream_q.size() + bits_q.size() / 16;
    while (bits_q.size() > 0) begin
      for (j = 0; j < 8; j++) b[7-j] = bits_q.pop_front();
      stream_q.push_back(b);
      eoi_q.push_back(bits_q.size() == 0);
    end
    // words after the finish are ignored by the block
    for (j = 0; j < 16; j++) begin
      stream_q.push_back(8'($urandom_range(0, 255)));
      eoi_q.push_back(1'($urandom_range(0, 1)));
    end
  endtask

  // idle mix follows progress through the stream
  always @* begin
    if (word_idx < stream_q.size() / 3) begin
      idle_tx = 34;
      idle_rx = 47;
    end else if (word_idx < 2 * stream_q.size() / 3) begin
      idle_tx = 47;
      idle_rx = 34;
    end else begin
      idle_tx = 0;
      idle_rx = 0;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
      word_idx <= 0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= idle_rx);
      if (!in_valid || in_ready) begin
        if (word_idx < stream_q.size() && $urandom_range(0, 99) >= idle_tx &&
            !(word_idx == hold_at && pending != 0)) begin
          in_valid <= 1'b1;
          data_byte <= stream_q[word_idx];
          end_of_input <= eoi_q[word_idx];
          word_idx <= word_idx + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= LIMIT) begin
      $display("level_huffman_stream_decoder_unit regression: fail");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    data_byte = 8'd0;
    end_of_input = 1'b0;
    word_idx = 0;
    quiet = 0;
    build_stream();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (word_idx < stream_q.size() || (in_valid && !in_ready) || pending != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    $display("stream of %0d words: %0d levels, %0d leaf slots, %0d coded symbols",
             stream_q.size(), n_levels, n_slots, n_syms);
    $display("%0d result words checked, %0d errors", results_seen, errors);
    if (errors == 0 && pending == 0) begin
      $display("level_huffman_stream_decoder_unit regression: pass");
    end else begin
      $display("level_huffman_stream_decoder_unit regression: fail");
    end
    $finish;
  end

endmodule
